### design/smap_pkg.sv
// Shared types and constants of the slaved actuator distance map.
// No dependencies; imported by the square root and top modules.
package smap_pkg;

   // request command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X16   = 2'd2;

   localparam int DIM_REG_W = 7;
   localparam int RAD_REG_W = 8;
   localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RESET  = 7'd64;
   localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RESET = 7'd64;
   localparam logic [RAD_REG_W-1:0] RADIUS_RESET       = 8'd32;

   // request and response field widths
   localparam int COORD_W = 6;
   localparam int SQ_IN_W = 8;
   localparam int ROOT_W  = 12;
   localparam int RAD_SQ_W = 2 * RAD_REG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_Q_SETUP,
      ST_Q_SCAN,
      ST_Q_DRAIN,
      ST_Q_SQRT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

### design/smap_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smap_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/smap_row_scan.sv
// Nearest active column within the clipped window of one mask row.
// No dependencies; purely combinational.
module smap_row_scan #(
   parameter int MAX_DIM         = 64,
   parameter int MAX_WINDOW_HALF = 16
) (
   input  logic [MAX_DIM-1:0]                   row_bits,
   input  logic [$clog2(MAX_DIM)-1:0]           col,
   input  logic [$clog2(MAX_WINDOW_HALF+1)-1:0] left_span,
   input  logic [$clog2(MAX_WINDOW_HALF+1)-1:0] right_span,
   output logic                                 found,
   output logic [$clog2(MAX_WINDOW_HALF+1)-1:0] dx
);

   localparam int SW  = $clog2(MAX_WINDOW_HALF + 1);
   localparam int EW  = MAX_DIM + 2 * MAX_WINDOW_HALF;
   localparam int WIN = 2 * MAX_WINDOW_HALF + 1;

   logic [EW-1:0]  ext_row;
   logic [EW-1:0]  shifted;
   logic [WIN-1:0] win;
   logic [MAX_WINDOW_HALF:0] hit;

   // pad both sides so the window centered on col never leaves the vector
   assign ext_row = {{MAX_WINDOW_HALF{1'b0}}, row_bits, {MAX_WINDOW_HALF{1'b0}}};
   assign shifted = ext_row >> col;
   assign win     = shifted[WIN-1:0];

   always_comb begin
      for (int d = 0; d <= MAX_WINDOW_HALF; d++) begin
         hit[d] = ((SW'(d) <= right_span) && win[MAX_WINDOW_HALF + d]) ||
                  ((SW'(d) <= left_span)  && win[MAX_WINDOW_HALF - d]);
      end
   end

   // keep the smallest offset that hits
   always_comb begin
      found = 1'b0;
      dx    = '0;
      for (int d = MAX_WINDOW_HALF; d >= 0; d--) begin
         if (hit[d]) begin
            found = 1'b1;
            dx    = SW'(d);
         end
      end
   end

endmodule

### design/smap_sqrt.sv
// Iterative square root, two radicand bits per cycle, rounded to nearest.
// Depends on smap_pkg for widths and the status struct.
module smap_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [smap_pkg::SQ_IN_W-1:0]   radicand,
   output smap_pkg::sqrt_status_type      status,
   output logic [smap_pkg::ROOT_W-1:0]    root
);
   import smap_pkg::*;

   localparam int NW    = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   logic             busy_ff, busy_in;
   logic             round_ff, round_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0] rem_ff, rem_in;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic [REM_W-1:0] rem_step;
   logic [ROOT_W-1:0] root_step;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NW-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_step  = REM_W'(rem_sh - trial);
         root_step = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_step  = REM_W'(rem_sh);
         root_step = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      round_in = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W - 1);
         num_in  = {radicand, {(NW-SQ_IN_W){1'b0}}};
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in  = num_ff << 2;
         root_in = root_step;
         rem_in  = rem_step;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in  = 1'b0;
            round_in = 1'b1;
         end
      end else if (round_ff) begin
         // round up when the remainder exceeds the root
         root_in = root_ff + ROOT_W'(rem_ff > REM_W'(root_ff));
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign status.busy = busy_ff | round_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

### design/slaved_actuator_distance_map_unit.sv
// Slaved actuator distance map: mask store, window scan sequencer, response register.
// Depends on smap_pkg, smap_ram, smap_row_scan and smap_sqrt.
//
// Usage:
//   The request channel (req_*) carries one command per request. A write
//   (command 0) stores one mask bit and gives no response; a write to a pixel
//   outside the store is dropped. A query (command 1) gives one response on
//   the rsp_* channel: the squared distance to the nearest qualifying active
//   pixel, the distance in 8 fractional bits, and a slaved flag.
//   A query scans the clipped window one mask row per cycle through the row RAM
//   read port, then runs a square root. The window spans at most 2*half+1
//   rows; a query outside the image skips the scan, and one with nothing found
//   skips the square root.
//   One request is in work at a time; req_ready is low until it finishes.
//   The response register holds a finished result while rsp_ready is low and a
//   new request is taken meanwhile; a query that finishes while the register is
//   still full waits in its final state.
//   The csr_* port writes image width, image height and radius (in 1/16 pixel);
//   write only while idle.
//   Reset is synchronous; it clears one valid bit per mask row, so the whole
//   mask reads as zero at once, with no clearing pass.
module slaved_actuator_distance_map_unit #(
   parameter int MAX_DIM         = 64,
   parameter int MAX_WINDOW_HALF = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [smap_pkg::COORD_W-1:0]      req_col,
   input  logic [smap_pkg::COORD_W-1:0]      req_row,
   input  logic                              req_active,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [smap_pkg::SQ_IN_W-1:0]      rsp_sq_distance,
   output logic [smap_pkg::ROOT_W-1:0]       rsp_distance_q8,
   output logic                              rsp_slaved,
   input  logic                              csr_wr_en,
   input  logic [smap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [smap_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import smap_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int SW     = $clog2(MAX_WINDOW_HALF + 1);
   localparam int D2W    = 2 * SW + 1;
   localparam int CW_RAW = $clog2(MAX_DIM + MAX_WINDOW_HALF + 1);
   localparam int CW     = (CW_RAW > DIM_REG_W) ? CW_RAW : DIM_REG_W;
   localparam int LW     = 2 * CW;
   localparam int RW     = (D2W + 8 > RAD_SQ_W) ? D2W + 8 : RAD_SQ_W;

   // configuration
   logic [DIM_REG_W-1:0] width_ff, height_ff;
   logic [RAD_REG_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_REG_W-1:0];
            CSR_RADIUS_X16:   radius_ff <= csr_wdata[RAD_REG_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] w_ext, h_ext, w_eff, h_eff;

   assign w_ext = CW'(width_ff);
   assign h_ext = CW'(height_ff);
   assign w_eff = (w_ext == '0) ? CW'(1) : ((w_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : w_ext);
   assign h_eff = (h_ext == '0) ? CW'(1) : ((h_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : h_ext);

   // state and working registers
   state_type state_ff, state_in;

   logic [DIM_W-1:0]    wr_col_ff, wr_col_in;
   logic [DIM_W-1:0]    wr_row_ff, wr_row_in;
   logic                wr_act_ff, wr_act_in;
   logic [CW-1:0]       x_ff, x_in;
   logic [CW-1:0]       y_ff, y_in;
   logic [CW-1:0]       iy_ff, iy_in;
   logic [CW-1:0]       y1_ff, y1_in;
   logic [SW-1:0]       left_ff, left_in;
   logic [SW-1:0]       right_ff, right_in;
   logic [RAD_SQ_W-1:0] rad_sq_ff, rad_sq_in;
   logic [LW-1:0]       lim_sq_ff, lim_sq_in;
   logic [D2W-1:0]      best_ff, best_in;
   logic                best_found_ff, best_found_in;
   logic                center_hit_ff, center_hit_in;
   logic                res_ok_ff, res_ok_in;

   logic [MAX_DIM-1:0]  row_vld_ff, row_vld_in;
   logic                rv_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [SW-1:0]       s1_dy_ff, s1_dy_in;
   logic                s2_valid_ff, s2_found_ff;
   logic [SW-1:0]       s2_dx_ff, s2_dy_ff;
   logic                s3_valid_ff, s3_found_ff, s3_center_ff;
   logic [D2W-1:0]      s3_d2_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SQ_IN_W-1:0]  rsp_sq_ff, rsp_sq_in;
   logic [ROOT_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic                rsp_slaved_ff, rsp_slaved_in;

   // mask store and helpers
   logic [DIM_W-1:0]    rd_addr;
   logic [MAX_DIM-1:0]  ram_rdata;
   logic [MAX_DIM-1:0]  row_bits;
   logic [MAX_DIM-1:0]  bit_mask;
   logic [MAX_DIM-1:0]  wr_data;
   logic                wr_en;

   logic                scan_found;
   logic [SW-1:0]       scan_dx;

   logic                sqrt_start;
   sqrt_status_type     sqrt_status;
   logic [ROOT_W-1:0]   sqrt_root;

   logic                req_accept;
   logic                in_store;
   logic [4:0]          half_raw;
   logic [CW-1:0]       half, x0, x1, y0, y1;
   logic                out_of_image;
   logic [CW:0]         wh_sum;
   logic [CW-1:0]       lim;
   logic                pipe_empty;
   logic                qualifies;
   logic                rsp_load;

   logic [2*SW-1:0]     dx_sq, dy_sq;
   logic [D2W-1:0]      d2;

   assign rd_addr  = (state_ff == ST_IDLE) ? DIM_W'(req_row) : iy_ff[DIM_W-1:0];
   assign row_bits = rv_ff ? ram_rdata : '0;
   assign bit_mask = MAX_DIM'(1) << wr_col_ff;
   assign wr_data  = (row_bits & ~bit_mask) | (wr_act_ff ? bit_mask : '0);
   assign wr_en    = (state_ff == ST_WR_MOD);

   smap_ram #(
      .WIDTH (MAX_DIM),
      .DEPTH (MAX_DIM)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   smap_row_scan #(
      .MAX_DIM         (MAX_DIM),
      .MAX_WINDOW_HALF (MAX_WINDOW_HALF)
   ) u_row_scan (
      .row_bits   (row_bits),
      .col        (x_ff[DIM_W-1:0]),
      .left_span  (left_ff),
      .right_span (right_ff),
      .found      (scan_found),
      .dx         (scan_dx)
   );

   smap_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (SQ_IN_W'(best_ff)),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   // window bounds for the captured query
   always_comb begin
      half_raw = {1'b0, radius_ff[RAD_REG_W-1:4]} + 5'd1;
      half     = (CW'(half_raw) > CW'(MAX_WINDOW_HALF)) ? CW'(MAX_WINDOW_HALF)
                                                        : CW'(half_raw);
      x0 = (x_ff > half) ? x_ff - half : '0;
      y0 = (y_ff > half) ? y_ff - half : '0;
      x1 = (x_ff + half > w_eff - CW'(1)) ? w_eff - CW'(1) : x_ff + half;
      y1 = (y_ff + half > h_eff - CW'(1)) ? h_eff - CW'(1) : y_ff + half;
      out_of_image = (x_ff >= w_eff) || (y_ff >= h_eff);
      wh_sum = {1'b0, w_eff} + {1'b0, h_eff};
      lim    = wh_sum[CW:1];
   end

   assign dx_sq = s2_dx_ff * s2_dx_ff;
   assign dy_sq = s2_dy_ff * s2_dy_ff;
   assign d2    = {1'b0, dx_sq} + {1'b0, dy_sq};

   assign req_accept = req_valid && req_ready;
   assign in_store   = (CW'(req_col) < CW'(MAX_DIM)) && (CW'(req_row) < CW'(MAX_DIM));
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign qualifies  = best_found_ff && !center_hit_ff && (LW'(best_ff) <= lim_sq_ff);

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      wr_col_in     = wr_col_ff;
      wr_row_in     = wr_row_ff;
      wr_act_in     = wr_act_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      iy_in         = iy_ff;
      y1_in         = y1_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      rad_sq_in     = rad_sq_ff;
      lim_sq_in     = lim_sq_ff;
      best_in       = best_ff;
      best_found_in = best_found_ff;
      center_hit_in = center_hit_ff;
      res_ok_in     = res_ok_ff;
      row_vld_in    = row_vld_ff;
      s1_valid_in   = 1'b0;
      s1_dy_in      = SW'((iy_ff > y_ff) ? iy_ff - y_ff : y_ff - iy_ff);
      sqrt_start    = 1'b0;
      rsp_load      = 1'b0;

      // fold in a finished row candidate
      if (s3_valid_ff && s3_found_ff) begin
         if (s3_center_ff) begin
            center_hit_in = 1'b1;
         end
         if ((RW'({s3_d2_ff, 8'b0}) < RW'(rad_sq_ff)) &&
             (!best_found_ff || (s3_d2_ff < best_ff))) begin
            best_in       = s3_d2_ff;
            best_found_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               wr_col_in = DIM_W'(req_col);
               wr_row_in = DIM_W'(req_row);
               wr_act_in = req_active;
               x_in      = CW'(req_col);
               y_in      = CW'(req_row);
               if (req_command == CMD_QUERY) begin
                  state_in = ST_Q_SETUP;
               end else if (in_store) begin
                  state_in = ST_WR_MOD;
               end
            end
         end
         ST_WR_MOD: begin
            row_vld_in[wr_row_ff] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_Q_SETUP: begin
            iy_in         = y0;
            y1_in         = y1;
            left_in       = SW'(x_ff - x0);
            right_in      = SW'(x1 - x_ff);
            rad_sq_in     = radius_ff * radius_ff;
            lim_sq_in     = lim * lim;
            best_found_in = 1'b0;
            center_hit_in = 1'b0;
            if (out_of_image) begin
               res_ok_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_Q_SCAN;
            end
         end
         ST_Q_SCAN: begin
            s1_valid_in = 1'b1;
            iy_in       = iy_ff + CW'(1);
            if (iy_ff == y1_ff) begin
               state_in = ST_Q_DRAIN;
            end
         end
         ST_Q_DRAIN: begin
            if (pipe_empty) begin
               if (qualifies) begin
                  sqrt_start = 1'b1;
                  state_in   = ST_Q_SQRT;
               end else begin
                  res_ok_in = 1'b0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_Q_SQRT: begin
            if (sqrt_status.done && !sqrt_status.busy) begin
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sq_in     = rsp_sq_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_slaved_in = rsp_slaved_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sq_in     = res_ok_ff ? SQ_IN_W'(best_ff) : '0;
         rsp_dist_in   = res_ok_ff ? sqrt_root : '0;
         rsp_slaved_in = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_vld_ff   <= '0;
         rv_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_vld_ff   <= row_vld_in;
         rv_ff        <= row_vld_ff[rd_addr];
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_col_ff     <= wr_col_in;
      wr_row_ff     <= wr_row_in;
      wr_act_ff     <= wr_act_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      iy_ff         <= iy_in;
      y1_ff         <= y1_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      rad_sq_ff     <= rad_sq_in;
      lim_sq_ff     <= lim_sq_in;
      best_ff       <= best_in;
      best_found_ff <= best_found_in;
      center_hit_ff <= center_hit_in;
      res_ok_ff     <= res_ok_in;
      s1_dy_ff      <= s1_dy_in;
      s2_found_ff   <= scan_found;
      s2_dx_ff      <= scan_dx;
      s2_dy_ff      <= s1_dy_ff;
      s3_found_ff   <= s2_found_ff;
      s3_center_ff  <= (s2_dx_ff == '0) && (s2_dy_ff == '0);
      s3_d2_ff      <= d2;
      rsp_sq_ff     <= rsp_sq_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_slaved_ff <= rsp_slaved_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sq_distance = rsp_sq_ff;
   assign rsp_distance_q8 = rsp_dist_ff;
   assign rsp_slaved      = rsp_slaved_ff;

endmodule
